// ----- src/adclz_pkg.sv -----
// Shared constants and types for the ADC LZ decompressor.
package adclz_pkg;

  localparam int POS_W     = 25;
  localparam int HIST_AW   = 16;
  localparam int OUT_LANES = 4;
  localparam int LANE_AW   = $clog2(OUT_LANES);
  localparam int CNT_W     = 3;
  localparam int LEN_W     = 7;
  localparam int TDATA_W   = 64;

  localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'(65536);

  // decode phases
  localparam logic [2:0] PH_CMD      = 3'd0;
  localparam logic [2:0] PH_LIT      = 3'd1;
  localparam logic [2:0] PH_LONG_HI  = 3'd2;
  localparam logic [2:0] PH_LONG_LO  = 3'd3;
  localparam logic [2:0] PH_SHORT_LO = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OFFSET    = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [7:0]         data;
  } hist_wr_t;

endpackage

// ----- src/adclz_hist.sv -----
// History window: 64 KiB byte memory, one write port, one registered read port.
module adclz_hist
  import adclz_pkg::*;
(
  input  logic               clk,
  input  hist_wr_t           wr,
  input  logic               rd_en,
  input  logic [HIST_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [2**HIST_AW];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/adc_lz_decompressor.sv -----
// ADC LZ decompressor top level: command decoder, copy sequencer and result packer.
// One compressed byte is taken per input transaction and every input gives one or more
// results of up to four bytes; in_tready is high only while the sequencer is idle.
// A command or offset byte passes through capture, decode and result states, the result
// waiting for out_tready; a literal byte the same. A copy adds a setup state and then a
// read and a write state per copied byte, since each byte is read from the single history
// port and written back before the next read, plus a result state for each further
// four-byte result handed off. The history memory is not cleared after reset; the
// offset check keeps unwritten entries from ever being read. output_limit may be
// written only while the block is idle.
module adc_lz_decompressor
  import adclz_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration: output_limit
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [POS_W-1:0]   cfg_data,
  // compressed input
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] in_byte
  input  logic               in_tuser,   // [0] chunk_first
  input  logic               in_tlast,   // chunk_last
  // decompressed results
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [7:0] out_byte0, [15:8] out_byte1,
                                         // [23:16] out_byte2, [31:24] out_byte3,
                                         // [34:32] byte_count, [36:35] status,
                                         // [61:37] produced_length, [63:62] zero
  output logic               out_tuser,  // [0] chunk_done
  output logic               out_tlast   // run_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CSET = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               first_r, first_nxt;
  logic               last_r, last_nxt;
  logic [POS_W-1:0]   wp_r, wp_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [7:0]         lit_r, lit_nxt;
  logic [LEN_W-1:0]   clen_r, clen_nxt;
  logic [7:0]         ohp_r, ohp_nxt;
  logic [1:0]         err_r, err_nxt;
  logic [POS_W-1:0]   limit_r, limit_nxt;
  logic [HIST_AW-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [7:0]         lane_r [OUT_LANES];
  logic [7:0]         lane_nxt [OUT_LANES];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // values after the chunk_first clear and phase normalization
  logic [POS_W-1:0]   wp_e;
  logic [2:0]         phase_e;
  logic [7:0]         lit_e;
  logic [LEN_W-1:0]   clen_e;
  logic [7:0]         ohp_e;
  logic [1:0]         err_e;
  logic [16:0]        offset_w;
  logic               off_bad;
  logic               wp_full;
  logic [POS_W-1:0]   room;

  hist_wr_t           hwr;
  logic               hrd_en;
  logic [7:0]         hrd_data;

  adclz_hist u_hist (
    .clk     (clk),
    .wr      (hwr),
    .rd_en   (hrd_en),
    .rd_addr (src_r),
    .rd_data (hrd_data)
  );

  assign wp_e    = first_r ? '0 : wp_r;
  assign phase_e = (first_r || phase_r > PH_SHORT_LO) ? PH_CMD : phase_r;
  assign lit_e   = first_r ? '0 : lit_r;
  assign clen_e  = first_r ? '0 : clen_r;
  assign ohp_e   = first_r ? '0 : ohp_r;
  assign err_e   = first_r ? ST_OK : err_r;

  assign offset_w = (phase_e == PH_LONG_LO) ? ({1'b0, ohp_e, byte_r} + 17'd1)
                                            : ({7'b0, ohp_e[1:0], byte_r} + 17'd1);
  assign off_bad  = {{(POS_W-17){1'b0}}, offset_w} > wp_e;
  assign wp_full  = wp_e >= limit_r;
  assign room     = limit_r - wp_r;

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    wp_nxt    = wp_r;
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    clen_nxt  = clen_r;
    ohp_nxt   = ohp_r;
    err_nxt   = err_r;
    limit_nxt = limit_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    lane_nxt  = lane_r;
    cnt_nxt   = cnt_r;
    hwr       = '0;
    hrd_en    = 1'b0;

    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          first_nxt = in_tuser;
          last_nxt  = in_tlast;
          for (int i = 0; i < OUT_LANES; i++) begin
            lane_nxt[i] = '0;
          end
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        wp_nxt    = wp_e;
        phase_nxt = phase_e;
        lit_nxt   = lit_e;
        clen_nxt  = clen_e;
        ohp_nxt   = ohp_e;
        err_nxt   = err_e;
        state_nxt = S_OUT;
        if (err_e == ST_OK) begin
          case (phase_e)
            PH_LIT: begin
              if (wp_full) begin
                err_nxt = ST_LIMIT;
              end else begin
                lane_nxt[0] = byte_r;
                cnt_nxt     = CNT_W'(1);
                hwr.en      = 1'b1;
                hwr.addr    = wp_e[HIST_AW-1:0];
                hwr.data    = byte_r;
                wp_nxt      = wp_e + POS_W'(1);
                lit_nxt     = lit_e - 8'd1;
                if (lit_nxt == 8'd0) begin
                  phase_nxt = PH_CMD;
                end
              end
            end
            PH_LONG_HI: begin
              ohp_nxt   = byte_r;
              phase_nxt = PH_LONG_LO;
            end
            PH_LONG_LO, PH_SHORT_LO: begin
              phase_nxt = PH_CMD;
              if (off_bad) begin
                err_nxt = ST_OFFSET;
              end else begin
                src_nxt   = wp_e[HIST_AW-1:0] - offset_w[HIST_AW-1:0];
                state_nxt = S_CSET;
              end
            end
            default: begin
              if (wp_full) begin
                err_nxt = ST_LIMIT;
              end else if (byte_r[7]) begin
                lit_nxt   = {1'b0, byte_r[6:0]} + 8'd1;
                phase_nxt = PH_LIT;
              end else if (byte_r[6]) begin
                clen_nxt  = {1'b0, byte_r[5:0]} + LEN_W'(4);
                phase_nxt = PH_LONG_HI;
              end else begin
                clen_nxt  = {1'b0, byte_r[7:2]} + LEN_W'(3);
                ohp_nxt   = {6'b0, byte_r[1:0]};
                phase_nxt = PH_SHORT_LO;
              end
            end
          endcase
          if (last_r && err_nxt == ST_OK && phase_nxt != PH_CMD) begin
            err_nxt = ST_TRUNCATED;
          end
        end
        if (last_r) begin
          phase_nxt = PH_CMD;
          lit_nxt   = '0;
        end
      end
      S_CSET: begin
        // clip the copy at the output limit
        if (wp_r >= limit_r) begin
          err_nxt = ST_LIMIT;
          rem_nxt = '0;
        end else if ({{(POS_W-LEN_W){1'b0}}, clen_r} > room) begin
          err_nxt = ST_LIMIT;
          rem_nxt = room[LEN_W-1:0];
        end else begin
          rem_nxt = clen_r;
        end
        state_nxt = (rem_nxt == '0) ? S_OUT : S_RD;
      end
      S_RD: begin
        hrd_en    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        lane_nxt[cnt_r[LANE_AW-1:0]] = hrd_data;
        hwr.en    = 1'b1;
        hwr.addr  = wp_r[HIST_AW-1:0];
        hwr.data  = hrd_data;
        wp_nxt    = wp_r + POS_W'(1);
        src_nxt   = src_r + HIST_AW'(1);
        rem_nxt   = rem_r - LEN_W'(1);
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = (cnt_nxt == CNT_W'(OUT_LANES) || rem_nxt == '0) ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (out_tready) begin
          for (int i = 0; i < OUT_LANES; i++) begin
            lane_nxt[i] = '0;
          end
          cnt_nxt   = '0;
          state_nxt = (rem_r != '0) ? S_RD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      phase_r <= PH_CMD;
      lit_r   <= '0;
      clen_r  <= '0;
      ohp_r   <= '0;
      err_r   <= ST_OK;
      limit_r <= LIMIT_RESET;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      clen_r  <= clen_nxt;
      ohp_r   <= ohp_nxt;
      err_r   <= err_nxt;
      limit_r <= limit_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    src_r   <= src_nxt;
    lane_r  <= lane_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (rem_r == '0);
  assign out_tuser  = last_r && (rem_r == '0);
  assign out_tdata  = {2'b00, wp_r, err_r, cnt_r, lane_r[3], lane_r[2], lane_r[1], lane_r[0]};

  // results are never offered while an input is being taken
  a_out_excl_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("result offered while input ready");

  // every result but the last of an input carries a full set of lanes
  a_full_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[34:32] == CNT_W'(OUT_LANES)))
    else $error("partial result before end of input");

  // chunk_done only on the last result of an input
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("chunk_done without run_last");

  // each copied byte advances the write position by one
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (wp_r == $past(wp_r) + POS_W'(1)))
    else $error("write position did not advance on copied byte");

endmodule

// ----- tb/adc_lz_decompressor_tb.sv -----
// Self-checking testbench for the ADC LZ decompressor: directed and random chunks.
`timescale 1ns / 100ps

module adc_lz_decompressor_tb
  import adclz_pkg::*;
();

  typedef struct packed {
    logic [POS_W-1:0]           produced;
    logic                       chunk_done;
    logic [1:0]                 status;
    logic                       run_last;
    logic [CNT_W-1:0]           count;
    logic [OUT_LANES-1:0][7:0]  lanes;
  } adc_block_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } adc_in_t;

  // Decode state mirror plus the queue of result blocks still owed by the block.
  class adc_decode_scoreboard;
    logic [7:0]       hist [0:65535];
    logic [POS_W-1:0] wr_pos;
    logic [2:0]       phase;
    logic [7:0]       lit_left;
    logic [LEN_W-1:0] cp_len;
    logic [7:0]       off_hi;
    logic [1:0]       err;
    logic [POS_W-1:0] limit;
    logic [7:0]       produced[$];
    adc_block_t       expected_blocks[$];
    int               errors;

    function new();
      wr_pos   = '0;
      phase    = PH_CMD;
      lit_left = '0;
      cp_len   = '0;
      off_hi   = '0;
      err      = ST_OK;
      limit    = LIMIT_RESET;
      errors   = 0;
    endfunction

    function void set_limit(logic [POS_W-1:0] val);
      limit = val;
    endfunction

    function bit put_byte(logic [7:0] v);
      if (wr_pos >= limit) begin
        err = ST_LIMIT;
        return 1'b0;
      end
      hist[wr_pos[HIST_AW-1:0]] = v;
      wr_pos = wr_pos + POS_W'(1);
      produced.push_back(v);
      return 1'b1;
    endfunction

    // Copy byte by byte so an overlapping copy re-reads its own output.
    function void run_copy(int unsigned offset, int unsigned len);
      logic [POS_W-1:0] src;
      if (offset > 32'(wr_pos)) begin
        err = ST_OFFSET;
        return;
      end
      for (int unsigned i = 0; i < len; i++) begin
        src = wr_pos - offset[POS_W-1:0];
        if (!put_byte(hist[src[HIST_AW-1:0]]))
          break;
      end
    endfunction

    function void decode_byte(logic [7:0] b, logic first, logic last);
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] pos;
      int unsigned      n;
      int unsigned      nres;
      int unsigned      cnt;
      adc_block_t       r;
      if (first) begin
        wr_pos   = '0;
        phase    = PH_CMD;
        lit_left = '0;
        cp_len   = '0;
        off_hi   = '0;
        err      = ST_OK;
      end
      if (phase > PH_SHORT_LO)
        phase = PH_CMD;
      produced.delete();
      start_pos = wr_pos;

      if (err == ST_OK) begin
        case (phase)
          PH_LIT: begin
            if (put_byte(b)) begin
              lit_left = lit_left - 8'd1;
              if (lit_left == 8'd0)
                phase = PH_CMD;
            end
          end
          PH_LONG_HI: begin
            off_hi = b;
            phase  = PH_LONG_LO;
          end
          PH_LONG_LO: begin
            phase = PH_CMD;
            run_copy({off_hi, b} + 1, 32'(cp_len));
          end
          PH_SHORT_LO: begin
            phase = PH_CMD;
            run_copy({off_hi[1:0], b} + 1, 32'(cp_len));
          end
          default: begin
            if (wr_pos >= limit) begin
              err = ST_LIMIT;
            end else if (b[7]) begin
              lit_left = {1'b0, b[6:0]} + 8'd1;
              phase    = PH_LIT;
            end else if (b[6]) begin
              cp_len = {1'b0, b[5:0]} + LEN_W'(4);
              phase  = PH_LONG_HI;
            end else begin
              cp_len = {1'b0, b[7:2]} + LEN_W'(3);
              off_hi = {6'd0, b[1:0]};
              phase  = PH_SHORT_LO;
            end
          end
        endcase
        if (last && err == ST_OK && phase != PH_CMD)
          err = ST_TRUNCATED;
      end
      if (last) begin
        phase    = PH_CMD;
        lit_left = '0;
      end

      // Pack the bytes of this input four to a block; no bytes still gives one block.
      n    = produced.size();
      nres = (n == 0) ? 1 : (n + OUT_LANES - 1) / OUT_LANES;
      pos  = start_pos;
      for (int unsigned k = 0; k < nres; k++) begin
        cnt = (n > k * OUT_LANES) ? n - k * OUT_LANES : 0;
        if (cnt > OUT_LANES)
          cnt = OUT_LANES;
        r.lanes = '0;
        for (int unsigned j = 0; j < cnt; j++)
          r.lanes[j] = produced[k * OUT_LANES + j];
        pos          = pos + cnt[POS_W-1:0];
        r.count      = cnt[CNT_W-1:0];
        r.run_last   = (k + 1 == nres);
        r.status     = err;
        r.chunk_done = last && (k + 1 == nres);
        r.produced   = pos;
        expected_blocks.push_back(r);
      end
    endfunction

    function void compare_field(string what, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
        errors++;
      end
    endfunction

    function void check_block(logic [TDATA_W-1:0] tdata, logic tuser, logic tlast);
      adc_block_t want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual tdata %0h",
                 $time, tdata);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        for (int j = 0; j < OUT_LANES; j++)
          compare_field($sformatf("out_byte%0d", j), want.lanes[j], tdata[8*j +: 8]);
        compare_field("byte_count", want.count, tdata[34:32]);
        compare_field("status", want.status, tdata[36:35]);
        compare_field("produced_length", want.produced, tdata[61:37]);
        compare_field("chunk_done", want.chunk_done, tuser);
        compare_field("run_last", want.run_last, tlast);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 500000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [POS_W-1:0]   cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  logic               out_tlast;

  adc_decode_scoreboard sb = new();

  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycles    = 0;

  adc_lz_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result-side backpressure in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.decode_byte(in_tdata, in_tuser, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_block(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_item(input logic [7:0] d, input logic f, input logic l);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= f;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drain all owed results, then let the block settle before touching the register.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_blocks.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [POS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(val);
  endtask

  function automatic void push_byte(ref adc_in_t q[$], input logic [7:0] v);
    q.push_back('{data: v, first: 1'b0, last: 1'b0});
  endfunction

  // Well-formed command stream with random content, sometimes broken on purpose.
  function automatic void build_chunk(ref adc_in_t q[$]);
    int unsigned wp;
    int unsigned ncmd;
    int unsigned kind;
    int unsigned len;
    int unsigned off;
    int unsigned n;
    q.delete();
    wp   = 0;
    ncmd = $urandom_range(1, 6);
    for (int c = 0; c < ncmd; c++) begin
      kind = (wp == 0) ? 0 : $urandom_range(0, 2);
      case (kind)
        0: begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
          push_byte(q, 8'h80 | 8'(len - 1));
          repeat (len) push_byte(q, 8'($urandom));
        end
        1: begin
          len = $urandom_range(3, 18);
          off = $urandom_range(1, (wp < 1024) ? wp : 1024);
          push_byte(q, 8'(((len - 3) << 2) | ((off - 1) >> 8)));
          push_byte(q, 8'((off - 1) & 8'hFF));
        end
        default: begin
          len = $urandom_range(4, 67);
          off = $urandom_range(1, (wp < 65536) ? wp : 65536);
          push_byte(q, 8'h40 | 8'(len - 4));
          push_byte(q, 8'((off - 1) >> 8));
          push_byte(q, 8'((off - 1) & 8'hFF));
        end
      endcase
      wp += len;
    end
    q[0].first = 1'b1;
    q[q.size()-1].last = 1'b1;

    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(1, q.size());
          while (q.size() > n) void'(q.pop_back());
          q[q.size()-1].last = 1'b1;
        end
        1: q[$urandom_range(0, q.size() - 1)].data = 8'($urandom);
        2: begin
          repeat ($urandom_range(1, 4)) push_byte(q, 8'($urandom));
          q[q.size()-1].last = 1'($urandom);
        end
        default: q[0].first = 1'b0;
      endcase
    end
  endfunction

  task automatic run_random(input int target);
    adc_in_t chunk[$];
    int      sent;
    sent = 0;
    while (sent < target) begin
      build_chunk(chunk);
      foreach (chunk[i]) send_item(chunk[i].data, chunk[i].first, chunk[i].last);
      sent += chunk.size();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 30;
    stall_pct = 25;
    write_limit(LIMIT_RESET);

    // Literal run with extreme byte values, then an overlapping short copy.
    send_item(8'h83, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    // Longest long copy: seventeen result blocks from one byte.
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h03, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h12, 1'b0, 1'b1);
    // Continue the same chunk without a new start.
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h22, 1'b0, 1'b1);
    // Offset reaching past the history, then a byte swallowed by the sticky error.
    send_item(8'h3F, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b1);
    // Longest literal run cut short by the chunk end.
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h11, 1'b0, 1'b1);
    drain_results();

    // Copy running into the output limit partway through.
    write_limit(25'd6);
    send_item(8'h83, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h02, 1'b0, 1'b0);
    send_item(8'h03, 1'b0, 1'b0);
    send_item(8'h04, 1'b0, 1'b0);
    send_item(8'h04, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain_results();

    write_limit(25'd16777216);
    run_random(25);
    drain_results();

    gap_pct = 0;
    write_limit(25'd1);
    run_random(15);
    drain_results();

    gap_pct   = 20;
    stall_pct = 0;
    write_limit(POS_W'($urandom_range(20, 300)));
    run_random(25);
    drain_results();

    // Closing stretch at full rate on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    write_limit(LIMIT_RESET);
    run_random(35);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_blocks.size() != 0);
    repeat (50) @(posedge clk);

    if (sb.expected_blocks.size() != 0)
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               sb.expected_blocks.size());
    if (sb.errors == 0 && sb.expected_blocks.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
